/* rtl/core/assert_macros.svh */
// Assertion macros shared by the clipper RTL.
// Depends on nothing; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CPL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CPL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/cpl_pkg.sv */
// Package for the convex polygon line clipper: widths, constants, types.
// No dependencies.
package cpl_pkg;
    localparam int MAX_VERTICES = 16;
    localparam int VIDX_W       = $clog2(MAX_VERTICES);
    localparam int CNT_W        = 5;
    localparam int COORD_W      = 16;
    localparam int VERT_W       = 2 * COORD_W;
    localparam int OP_W         = 18;
    localparam int PROD_W       = 2 * OP_W;
    localparam int ACC_W        = 35;
    localparam int T_W          = 18;
    localparam int Q_W          = 17;
    localparam int REM_W        = 54;
    localparam int T_ONE        = 65536;
    localparam int T_MAX        = 65537;
    localparam int MIN_VERTICES = 3;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CLIP  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_LD0, S_LDB, S_M0, S_M1, S_M2, S_M3, S_EVAL, S_CHK,
        S_DIV, S_NEXT, S_FIN, S_LMUL, S_LACC, S_DONE
    } cpl_state_t;

    typedef struct packed {
        logic                  done;
        logic signed [T_W-1:0] t;
    } cpl_div_res_t;
endpackage

/* rtl/core/cpl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/core/cpl_divider.sv */
// Bit-serial restoring divider: t = round(num * 2^16 / den), clamped to -1..65537.
// Depends on cpl_pkg.
module cpl_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic signed [cpl_pkg::ACC_W-1:0]  num,
    input  logic signed [cpl_pkg::ACC_W-1:0]  den,
    output cpl_pkg::cpl_div_res_t             res
);
    import cpl_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  ds_reg;
    logic [Q_W-1:0]    q_reg;
    logic              neg_reg;
    logic              sat_reg;

    logic [ACC_W-1:0]  an;
    logic [ACC_W-1:0]  ad;
    logic [REM_W-1:0]  dividend;
    logic [REM_W-1:0]  dvs;
    logic [REM_W-1:0]  dlim;
    logic              ge;

    // Operand magnitudes and scaled dividend (2^17 * |num| + |den|) over 2*|den|
    always_comb
    begin
        an       = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
        ad       = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
        dividend = (REM_W'(an) << (Q_W)) + REM_W'(ad);
        dvs      = REM_W'(ad) << 1;
        dlim     = dvs << Q_W;
        ge       = rem_reg >= ds_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // One quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            ds_reg  <= dvs << (Q_W - 1);
            q_reg   <= '0;
            neg_reg <= num[ACC_W-1] ^ den[ACC_W-1];
            sat_reg <= dividend >= dlim;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - ds_reg;
            end
            q_reg  <= {q_reg[Q_W-2:0], ge};
            ds_reg <= ds_reg >> 1;
        end
    end

    // Sign and clamp
    always_comb
    begin
        res.done = done_reg;
        if (neg_reg)
        begin
            res.t = (sat_reg || (q_reg != '0)) ? -T_W'(1) : '0;
        end
        else if (sat_reg || (q_reg > Q_W'(T_MAX)))
        begin
            res.t = T_W'(T_MAX);
        end
        else
        begin
            res.t = T_W'(q_reg);
        end
    end
endmodule

/* rtl/core/convex_polygon_line_clipper.sv */
// Cyrus-Beck line clipper against a convex counter-clockwise window.
// A vertex write (cmd 0) leaves busy low. A clip (cmd 1) handles windows of
// 3 to 16 vertices edge by edge, then computes the clipped endpoints for the
// result beat; an edge parallel to the segment skips the divider, a rejection
// by a parallel edge ends early, and equal endpoints give the result beat in
// the next cycle. Each window edge uses the shared 18x18 multiplier (four
// products) and the serial divider (17 quotient bits). The result beat shows
// for one cycle with done high and cannot be held off.
// Depends on cpl_pkg, cpl_ram, cpl_divider and assert_macros.svh.
`include "assert_macros.svh"

module convex_polygon_line_clipper (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               cmd,
    input  logic [cpl_pkg::VIDX_W-1:0]         vertex_index,
    input  logic signed [cpl_pkg::COORD_W-1:0] vertex_x,
    input  logic signed [cpl_pkg::COORD_W-1:0] vertex_y,
    input  logic signed [cpl_pkg::COORD_W-1:0] start_x,
    input  logic signed [cpl_pkg::COORD_W-1:0] start_y,
    input  logic signed [cpl_pkg::COORD_W-1:0] start_z,
    input  logic signed [cpl_pkg::COORD_W-1:0] end_x,
    input  logic signed [cpl_pkg::COORD_W-1:0] end_y,
    input  logic signed [cpl_pkg::COORD_W-1:0] end_z,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cpl_pkg::CNT_W-1:0]          cfg_data,
    output logic                               done,
    output logic                               status,
    output logic signed [cpl_pkg::COORD_W-1:0] clip_start_x,
    output logic signed [cpl_pkg::COORD_W-1:0] clip_start_y,
    output logic signed [cpl_pkg::COORD_W-1:0] clip_start_z,
    output logic signed [cpl_pkg::COORD_W-1:0] clip_end_x,
    output logic signed [cpl_pkg::COORD_W-1:0] clip_end_y,
    output logic signed [cpl_pkg::COORD_W-1:0] clip_end_z
);
    import cpl_pkg::*;

    cpl_state_t state_reg, state_next;

    logic [CNT_W-1:0]          vcount_reg;
    logic [CNT_W-1:0]          n_reg;
    logic [VIDX_W-1:0]         i_reg;
    logic [2:0]                l_reg;
    logic signed [COORD_W-1:0] s_reg [3];
    logic signed [COORD_W-1:0] e_reg [3];
    logic signed [COORD_W-1:0] res_reg [6];
    logic signed [COORD_W-1:0] px_reg, py_reg, cx_reg, cy_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   den_reg, num_reg;
    logic signed [T_W-1:0]     te_reg, tl_reg;
    logic                      status_reg;

    logic                      accept;
    logic                      ram_we;
    logic [VIDX_W-1:0]         raddr;
    logic [VERT_W-1:0]         rdata;
    logic [CNT_W-1:0]          n_clamp;
    logic [CNT_W-1:0]          i_plus2;
    logic signed [OP_W-1:0]    mul_a, mul_b;
    logic signed [16:0]        nx, ny, dx, dy, rx, ry;
    logic [1:0]                lsel;
    logic signed [16:0]        ldiff;
    logic signed [PROD_W-1:0]  lsum;
    logic                      div_start;
    logic                      last_edge;
    cpl_div_res_t              div_res;

    assign accept    = start && !busy;
    assign busy      = state_reg != S_IDLE;
    assign cfg_ready = 1'b1;
    assign ram_we    = accept && (cmd == CMD_WRITE)
                       && ({1'b0, vertex_index} < (VIDX_W+1)'(MAX_VERTICES));
    assign div_start = (state_reg == S_CHK) && (den_reg != '0);
    assign last_edge = (CNT_W'(i_reg) + 1'b1) == n_reg;

    // Vertex table
    cpl_ram #(.WIDTH(VERT_W), .DEPTH(MAX_VERTICES)) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (vertex_index),
        .wdata ({vertex_y, vertex_x}),
        .raddr (raddr),
        .rdata (rdata)
    );

    cpl_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (den_reg),
        .res   (div_res)
    );

    // Vertex count clamp
    always_comb
    begin
        if (vcount_reg < CNT_W'(MIN_VERTICES))
        begin
            n_clamp = CNT_W'(MIN_VERTICES);
        end
        else if (vcount_reg > CNT_W'(MAX_VERTICES))
        begin
            n_clamp = CNT_W'(MAX_VERTICES);
        end
        else
        begin
            n_clamp = vcount_reg;
        end
    end

    // Read address: vertex 0 at accept, vertex 1 after it, then wrap(i+2)
    always_comb
    begin
        i_plus2 = CNT_W'(i_reg) + CNT_W'(2);
        if (i_plus2 >= n_reg)
        begin
            i_plus2 = i_plus2 - n_reg;
        end
        unique case (state_reg)
            S_LD0:   raddr = VIDX_W'(1);
            S_NEXT:  raddr = i_plus2[VIDX_W-1:0];
            default: raddr = '0;
        endcase
    end

    // Edge terms
    always_comb
    begin
        nx = 17'(py_reg) - 17'(cy_reg);
        ny = 17'(cx_reg) - 17'(px_reg);
        dx = 17'(e_reg[0]) - 17'(s_reg[0]);
        dy = 17'(e_reg[1]) - 17'(s_reg[1]);
        rx = 17'(px_reg) - 17'(s_reg[0]);
        ry = 17'(py_reg) - 17'(s_reg[1]);
        lsel  = (l_reg < 3'd3) ? l_reg[1:0] : 2'(l_reg - 3'd3);
        ldiff = 17'(e_reg[lsel]) - 17'(s_reg[lsel]);
        lsum  = prod_reg + PROD_W'(32768);
    end

    // Shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            S_M0:    begin mul_a = OP_W'(nx);    mul_b = OP_W'(dx); end
            S_M1:    begin mul_a = OP_W'(ny);    mul_b = OP_W'(dy); end
            S_M2:    begin mul_a = OP_W'(nx);    mul_b = OP_W'(rx); end
            S_M3:    begin mul_a = OP_W'(ny);    mul_b = OP_W'(ry); end
            S_LMUL:  begin mul_a = OP_W'(ldiff);
                           mul_b = (l_reg < 3'd3) ? te_reg : tl_reg; end
            default: begin mul_a = '0;           mul_b = '0; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd == CMD_CLIP))
                begin
                    if ((start_x == end_x) && (start_y == end_y) && (start_z == end_z))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LD0;
                    end
                end
            end
            S_LD0:  state_next = S_LDB;
            S_LDB:  state_next = S_M0;
            S_M0:   state_next = S_M1;
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_EVAL;
            S_EVAL: state_next = S_CHK;
            S_CHK:
            begin
                if (den_reg != '0)
                begin
                    state_next = S_DIV;
                end
                else if (num_reg > 0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = last_edge ? S_FIN : S_NEXT;
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    state_next = last_edge ? S_FIN : S_NEXT;
                end
            end
            S_NEXT: state_next = S_LDB;
            S_FIN:  state_next = (te_reg > tl_reg) ? S_DONE : S_LMUL;
            S_LMUL: state_next = S_LACC;
            S_LACC: state_next = (l_reg == 3'd5) ? S_DONE : S_LMUL;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            vcount_reg <= CNT_W'(4);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                vcount_reg <= cfg_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                s_reg[0]   <= start_x;
                s_reg[1]   <= start_y;
                s_reg[2]   <= start_z;
                e_reg[0]   <= end_x;
                e_reg[1]   <= end_y;
                e_reg[2]   <= end_z;
                n_reg      <= n_clamp;
                i_reg      <= '0;
                l_reg      <= '0;
                te_reg     <= '0;
                tl_reg     <= T_W'(T_ONE);
                status_reg <= (start_x == end_x) && (start_y == end_y)
                              && (start_z == end_z);
                for (int k = 0; k < 6; k++)
                begin
                    res_reg[k] <= '0;
                end
            end
            S_LD0:
            begin
                px_reg <= rdata[COORD_W-1:0];
                py_reg <= rdata[VERT_W-1:COORD_W];
            end
            S_LDB:
            begin
                cx_reg <= rdata[COORD_W-1:0];
                cy_reg <= rdata[VERT_W-1:COORD_W];
            end
            S_M1:   den_reg <= prod_reg[ACC_W-1:0];
            S_M2:   den_reg <= den_reg + prod_reg[ACC_W-1:0];
            S_M3:   num_reg <= prod_reg[ACC_W-1:0];
            S_EVAL: num_reg <= num_reg + prod_reg[ACC_W-1:0];
            S_CHK:
            begin
                if ((den_reg == '0) && (num_reg > 0))
                begin
                    status_reg <= 1'b1;
                end
            end
            S_DIV:
            begin
                // Entering edge raises tE, leaving edge lowers tL
                if (div_res.done)
                begin
                    if (!den_reg[ACC_W-1])
                    begin
                        if (div_res.t > te_reg)
                        begin
                            te_reg <= div_res.t;
                        end
                    end
                    else if (div_res.t < tl_reg)
                    begin
                        tl_reg <= div_res.t;
                    end
                end
            end
            S_NEXT:
            begin
                i_reg  <= i_reg + 1'b1;
                px_reg <= cx_reg;
                py_reg <= cy_reg;
            end
            S_FIN:
            begin
                if (te_reg > tl_reg)
                begin
                    status_reg <= 1'b1;
                end
            end
            S_LACC:
            begin
                res_reg[l_reg] <= s_reg[lsel] + lsum[COORD_W+15:16];
                l_reg          <= l_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Result beat
    assign done         = state_reg == S_DONE;
    assign status       = status_reg;
    assign clip_start_x = res_reg[0];
    assign clip_start_y = res_reg[1];
    assign clip_start_z = res_reg[2];
    assign clip_end_x   = res_reg[3];
    assign clip_end_y   = res_reg[4];
    assign clip_end_z   = res_reg[5];

    `CPL_ASSERT_NXT(a_done_frees, clk, rst_n, done, !busy, "busy after result beat")
    `CPL_ASSERT_IMP(a_reject_zero, clk, rst_n, done && status, (clip_start_x == 0) && (clip_end_x == 0) && (clip_start_y == 0) && (clip_end_y == 0), "rejected beat not zero")
    `CPL_ASSERT_NXT(a_write_idle, clk, rst_n, start && !busy && (cmd == CMD_WRITE), !busy && !done, "vertex write left idle")
endmodule
